### hw/rtl/pote_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pote_pkg
// Shared types, codes and defaults for the priority ordered entry table.
// ----------------------------------------------------------------------------
package pote_pkg;

    // Default table depth
    localparam int unsigned CAPACITY_DEF = 256;

    // Field widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned ID_W     = 10;
    localparam int unsigned INI_W    = 8;
    localparam int unsigned AGE_W    = 16;
    localparam int unsigned RANK_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCOUNT_W = 9;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_RANK  = 2'd3;

    // One stored entry
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [INI_W-1:0] ini;
        logic [AGE_W-1:0] age;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    // True when a new entry with these keys goes ahead of the stored one
    function automatic logic goes_ahead(input logic [INI_W-1:0] ini,
                                        input logic [AGE_W-1:0] age,
                                        input t_entry           e);
        goes_ahead = (ini > e.ini) || ((ini == e.ini) && (age >= e.age));
    endfunction

endpackage

### hw/rtl/pote_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pote_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pote_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/priority_ordered_entry_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ordered_entry_table_core
// Bounded table kept sorted by initiative then age (both highest first), with
// insert, remove-by-id and read-by-rank requests.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata (low bit up)                    | tuser
//  s_axis    | in  | entry_id, initiative, age, rank (48b) | mode
//  m_axis    | out | found_id, entry_count (24b)           | status
//
//  Each table step is a read of the entry RAM and a compare/move on the next
//  cycle. An insert visits the entries behind the new slot, a remove visits
//  every entry and a read visits only the ranked entry; a full insert, a bad
//  rank or an unused mode goes straight to the result. One request at a time.
//  Synchronous active-low reset empties the table; no clearing pass needed.
//  A result waiting on m_axis stalls only the final step of the next request.
// ----------------------------------------------------------------------------
module priority_ordered_entry_table_core #(
    parameter int unsigned CAPACITY = pote_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // entry_id[9:0], initiative[17:10], age[33:18], rank[41:34], zero[47:42]
    input  logic [47:0] i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // found_id[9:0], entry_count[18:10], zero[23:19]
    output logic [23:0] o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]  o_m_axis_tuser
);

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > pote_pkg::RANK_W) ? CW : pote_pkg::RANK_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Control registers
    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic                            r_ov, n_ov;
    // Request and work registers
    logic [pote_pkg::MODE_W-1:0]     r_mode, n_mode;
    logic [pote_pkg::ID_W-1:0]       r_id, n_id;
    logic [pote_pkg::INI_W-1:0]      r_ini, n_ini;
    logic [pote_pkg::AGE_W-1:0]      r_age, n_age;
    logic [CW-1:0]                   r_idx, n_idx;
    logic                            r_hit, n_hit;
    logic [pote_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [pote_pkg::ID_W-1:0]       r_found, n_found;
    // Output register
    logic [pote_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic [pote_pkg::ID_W-1:0]       r_out_found, n_out_found;
    logic [pote_pkg::OCOUNT_W-1:0]   r_out_count, n_out_count;

    // RAM port signals
    logic                            ram_we, ram_re;
    logic [AW-1:0]                   ram_waddr, ram_raddr;
    pote_pkg::t_entry                ram_wdata, ram_rdata;

    // Request field unpacking
    logic [pote_pkg::ID_W-1:0]       in_id;
    logic [pote_pkg::INI_W-1:0]      in_ini;
    logic [pote_pkg::AGE_W-1:0]      in_age;
    logic [pote_pkg::RANK_W-1:0]     in_rank;
    logic [CMPW-1:0]                 rank_ext, count_ext;
    logic [CW-1:0]                   idx_prev;
    pote_pkg::t_entry                new_entry;

    assign in_id     = i_s_axis_tdata[9:0];
    assign in_ini    = i_s_axis_tdata[17:10];
    assign in_age    = i_s_axis_tdata[33:18];
    assign in_rank   = i_s_axis_tdata[41:34];
    assign rank_ext  = CMPW'(in_rank);
    assign count_ext = CMPW'(r_count);
    assign idx_prev  = r_idx - 1'b1;
    assign new_entry = '{id: r_id, ini: r_ini, age: r_age};

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {5'd0, r_out_count, r_out_found};
    assign o_m_axis_tuser  = r_out_status;

    pote_ram #(
        .WIDTH (pote_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer: insert walks down from the tail moving entries up one slot,
    // remove walks up from the head closing the gap behind the match.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ov         = r_ov && !i_m_axis_tready;
        n_mode       = r_mode;
        n_id         = r_id;
        n_ini        = r_ini;
        n_age        = r_age;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_status     = r_status;
        n_found      = r_found;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = new_entry;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_mode   = i_s_axis_tuser;
                    n_id     = in_id;
                    n_ini    = in_ini;
                    n_age    = in_age;
                    n_hit    = 1'b0;
                    n_found  = '0;
                    n_status = pote_pkg::ST_OK;
                    case (i_s_axis_tuser)
                        pote_pkg::MODE_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = pote_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_RD;
                            end
                        end
                        pote_pkg::MODE_REMOVE: begin
                            n_idx   = '0;
                            n_state = S_RD;
                        end
                        pote_pkg::MODE_READ: begin
                            if (rank_ext < count_ext) begin
                                ram_re    = 1'b1;
                                ram_raddr = rank_ext[AW-1:0];
                                n_state   = S_CMP;
                            end else begin
                                n_status = pote_pkg::ST_BAD_RANK;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Issue the read for the next entry, or finish the walk
            S_RD: begin
                case (r_mode)
                    pote_pkg::MODE_INSERT: begin
                        if (r_idx == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            n_count   = r_count + 1'b1;
                            n_state   = S_DONE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = idx_prev[AW-1:0];
                            n_state   = S_CMP;
                        end
                    end
                    pote_pkg::MODE_REMOVE: begin
                        if (r_idx == r_count) begin
                            if (r_hit) begin
                                n_count = r_count - 1'b1;
                            end else begin
                                n_status = pote_pkg::ST_NOT_FOUND;
                            end
                            n_state = S_DONE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = r_idx[AW-1:0];
                            n_state   = S_CMP;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Compare the entry just read and move it or place the new one; a read takes its id
            S_CMP: begin
                case (r_mode)
                    pote_pkg::MODE_INSERT: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_idx[AW-1:0];
                        if (pote_pkg::goes_ahead(r_ini, r_age, ram_rdata)) begin
                            ram_wdata = ram_rdata;
                            n_idx     = idx_prev;
                            n_state   = S_RD;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_state = S_DONE;
                        end
                    end
                    pote_pkg::MODE_REMOVE: begin
                        if (r_hit) begin
                            ram_we    = 1'b1;
                            ram_waddr = idx_prev[AW-1:0];
                            ram_wdata = ram_rdata;
                        end else if (ram_rdata.id == r_id) begin
                            n_hit = 1'b1;
                        end
                        n_idx   = CW'(r_idx + 1'b1);
                        n_state = S_RD;
                    end
                    pote_pkg::MODE_READ: begin
                        n_found = ram_rdata.id;
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_ov || i_m_axis_tready) begin
                    n_ov         = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_count  = pote_pkg::OCOUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // Payload and work registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_id         <= n_id;
        r_ini        <= n_ini;
        r_age        <= n_age;
        r_idx        <= n_idx;
        r_hit        <= n_hit;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

`ifndef ASSERT_OFF
    // Fill count stays within the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // RAM is written only during a walk
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_RD || r_state == S_CMP))
        else $error("RAM write outside a walk");

    // Count moves by one, and only at the end of a walk
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |->
            (($past(r_state) == S_RD || $past(r_state) == S_CMP) &&
             (r_count == CW'($past(r_count) + 1'b1) ||
              r_count == CW'($past(r_count) - 1'b1))))
        else $error("entry count jumped");

    // A finished request never overwrites a result not yet taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_axis_tready && r_state == S_DONE) |=> r_state == S_DONE)
        else $error("result overwritten");
`endif

endmodule
